/* sv/lz48_stream_decompressor_top_defines.svh */
// Assertion macros for the LZ48 stream decompressor.
// Used by lz48_stream_decompressor_top; expects clk_i and rst_ni in scope.
`ifndef LZ48_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZ48_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LZ48_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication
`define LZ48_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define LZ48_ASSERT(lbl, pre, post, msg)
`define LZ48_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* sv/lz48_pkg.sv */
// Shared types and constants for the LZ48 stream decompressor.
// No dependencies.
`default_nettype none
package lz48_pkg;

  localparam int HistDepthDef = 256;
  localparam int LenWidthDef  = 16;

  localparam logic [3:0] NibbleExt = 4'hF;   // nibble that asks for extension bytes
  localparam logic [7:0] ExtByte   = 8'hFF;  // extension continues
  localparam logic [7:0] EndMarker = 8'hFF;  // offset byte that ends the stream
  localparam int         MatchMin  = 3;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_DRAIN   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_FIRST    = 3'd0,
    PH_TOKEN    = 3'd1,
    PH_LITEXT   = 3'd2,
    PH_LITERAL  = 3'd3,
    PH_MATCHEXT = 3'd4,
    PH_OFFSET   = 3'd5,
    PH_COPY     = 3'd6,
    PH_DONE     = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_COPY_BUSY = 3'd1,
    ST_NO_DRAIN  = 3'd2,
    ST_AFTER_END = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // per-beat decode result handed from the control unit to the datapath
  typedef struct packed {
    logic    emit;          // a byte goes out
    logic    hist_we;       // the byte is appended to history
    logic    from_hist;     // the byte comes from history, not the input
    status_e status;
    logic    copy_pending;
    logic    done;
  } step_t;

endpackage
`default_nettype wire

/* sv/lz48_stream_decompressor_top.sv */
// LZ48 stream decompressor: input stage, history RAM and result register.
// Depends on lz48_pkg, lz48_ctrl, lz48_ram and the assertion macro header.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per command:
//   opcode_i = data byte, drain one match byte, restart or no-op; in_byte_i is the
//   compressed byte for data beats. Every input beat yields exactly one
//   result beat on res_valid_o / res_stall_i with out_valid_o, out_byte_o,
//   copy_pending_o, stream_done_o and status_o.
//   Throughput: one beat per cycle while res_stall_i is low, including
//   back-to-back drains of overlapping copies (the history write of the
//   previous beat is forwarded to the next read). The rate is set by the
//   single history RAM port pair: one read and one write per beat.
//   Path: input acceptance, history read stage, then result register.
//   Stall: holding res_stall_i high freezes the result register; one more
//   beat is taken into the read stage, then in_stall_o rises.
//   Reset: the decoder expects the raw first byte, all counters are zero and
//   no result is pending. History contents are undefined until written and
//   are not cleared by reset or restart.
`default_nettype none
`include "lz48_stream_decompressor_top_defines.svh"
module lz48_stream_decompressor_top import lz48_pkg::*; #(
  parameter int HIST_DEPTH = HistDepthDef,
  parameter int LEN_WIDTH  = LenWidthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] in_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_stall_i,
  output logic            out_valid_o,
  output logic      [7:0] out_byte_o,
  output logic            copy_pending_o,
  output logic            stream_done_o,
  output logic      [2:0] status_o
);

  localparam int AW = $clog2(HIST_DEPTH);

  logic          accept;
  step_t         step;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    ram_rdata;

  // read stage
  logic          s1_valid_q;
  step_t         s1_step_q;
  logic [7:0]    s1_lit_q;
  logic [AW-1:0] s1_waddr_q;
  logic          s1_fwd_q;
  logic [7:0]    s1_fwd_data_q;
  logic          s1_adv;
  logic [7:0]    s1_byte;

  // result register
  logic          res_valid_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          copy_pending_q;
  logic          done_q;
  status_e       status_q;

  assign s1_adv     = s1_valid_q && (!res_valid_q || !res_stall_i);
  assign in_stall_o = s1_valid_q && res_valid_q && res_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  lz48_ctrl #(
    .HIST_DEPTH(HIST_DEPTH),
    .LEN_WIDTH (LEN_WIDTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (opcode_i),
    .in_byte_i(in_byte_i),
    .step_o   (step),
    .waddr_o  (waddr),
    .raddr_o  (raddr)
  );

  // history write trails the read by one beat; bypass when they collide
  assign s1_byte = !s1_step_q.from_hist ? s1_lit_q :
                   (s1_fwd_q ? s1_fwd_data_q : ram_rdata);

  lz48_ram #(
    .WIDTH(8),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (s1_adv && s1_step_q.hist_we),
    .waddr_i(s1_waddr_q),
    .wdata_i(s1_byte),
    .re_i   (accept),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_step_q     <= step;
      s1_lit_q      <= in_byte_i;
      s1_waddr_q    <= waddr;
      s1_fwd_q      <= s1_valid_q && s1_step_q.hist_we && (s1_waddr_q == raddr);
      s1_fwd_data_q <= s1_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_valid_q    <= s1_step_q.emit;
      out_byte_q     <= s1_step_q.emit ? s1_byte : 8'd0;
      copy_pending_q <= s1_step_q.copy_pending;
      done_q         <= s1_step_q.done;
      status_q       <= s1_step_q.status;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign copy_pending_o = copy_pending_q;
  assign stream_done_o  = done_q;
  assign status_o       = status_q;

  `LZ48_ASSERT(a_idle_byte_zero, res_valid_o && !out_valid_o, out_byte_o == 8'd0, "byte without valid")
  `LZ48_ASSERT(a_copy_xor_done, res_valid_o, !(copy_pending_o && stream_done_o), "copy after end")
  `LZ48_ASSERT(a_ovf_no_byte, res_valid_o && (status_o == ST_OVERFLOW), !out_valid_o, "overflow emitted")
  `LZ48_ASSERT_NEXT(a_accept_fills, accept, s1_valid_q, "accepted beat lost")

endmodule
`default_nettype wire

/* sv/lz48_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lz48_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/lz48_ctrl.sv */
// Token parser and length/position state for the LZ48 decoder.
// Depends on lz48_pkg. Updates its state on every accepted beat.
`default_nettype none
module lz48_ctrl import lz48_pkg::*; #(
  parameter int HIST_DEPTH = HistDepthDef,
  parameter int LEN_WIDTH  = LenWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [7:0]                    in_byte_i,
  output step_t                              step_o,
  output logic      [$clog2(HIST_DEPTH)-1:0] waddr_o,
  output logic      [$clog2(HIST_DEPTH)-1:0] raddr_o
);

  localparam int AW = $clog2(HIST_DEPTH);
  localparam int MW = LEN_WIDTH + 1;
  localparam logic [LEN_WIDTH-1:0] LenMax = {LEN_WIDTH{1'b1}};

  phase_e               phase_q, phase_d;
  logic [LEN_WIDTH-1:0] lit_q, lit_d;
  logic [MW-1:0]        match_q, match_d;
  logic [AW-1:0]        wpos_q, wpos_d;
  logic [AW-1:0]        cpos_q, cpos_d;

  op_e                  op;
  logic [LEN_WIDTH:0]   lit_sum, mext_sum;
  logic                 lit_ovf, mext_ovf;
  logic [LEN_WIDTH-1:0] lit_sat, lit_dec;
  logic [MW-1:0]        match_dec;

  assign op        = op_e'(opcode_i);
  assign lit_sum   = {1'b0, lit_q} + MW'(in_byte_i);
  assign mext_sum  = {1'b0, match_q[LEN_WIDTH-1:0]} + MW'(in_byte_i);
  assign lit_ovf   = lit_sum[LEN_WIDTH];
  assign mext_ovf  = mext_sum[LEN_WIDTH];
  assign lit_sat   = lit_ovf ? LenMax : lit_sum[LEN_WIDTH-1:0];
  assign lit_dec   = lit_q - LEN_WIDTH'(lit_q != '0);
  assign match_dec = match_q - MW'(match_q != '0);

  // next state
  always_comb begin
    phase_d = phase_q;
    lit_d   = lit_q;
    match_d = match_q;
    wpos_d  = wpos_q;
    cpos_d  = cpos_q;
    unique case (op)
      OP_RESTART: begin
        phase_d = PH_FIRST;
        lit_d   = '0;
        match_d = '0;
        wpos_d  = '0;
        cpos_d  = '0;
      end
      OP_DRAIN: begin
        if (phase_q == PH_COPY) begin
          wpos_d  = wpos_q + AW'(1);
          cpos_d  = cpos_q + AW'(1);
          match_d = match_dec;
          if (match_dec == '0) begin
            phase_d = PH_TOKEN;
          end
        end
      end
      OP_DATA: begin
        unique case (phase_q)
          PH_FIRST: begin
            wpos_d  = wpos_q + AW'(1);
            phase_d = PH_TOKEN;
          end
          PH_TOKEN: begin
            lit_d   = LEN_WIDTH'(in_byte_i[7:4]);
            match_d = MW'(in_byte_i[3:0]);
            if (in_byte_i[7:4] == NibbleExt) begin
              phase_d = PH_LITEXT;
            end else if (in_byte_i[7:4] != 4'd0) begin
              phase_d = PH_LITERAL;
            end else begin
              phase_d = (in_byte_i[3:0] == NibbleExt) ? PH_MATCHEXT : PH_OFFSET;
            end
          end
          PH_LITEXT: begin
            lit_d = lit_sat;
            if (in_byte_i != ExtByte) begin
              // a zero-length run would skip straight to the offset byte
              phase_d = (lit_sat != '0) ? PH_LITERAL : PH_OFFSET;
            end
          end
          PH_LITERAL: begin
            wpos_d = wpos_q + AW'(1);
            lit_d  = lit_dec;
            if (lit_dec == '0) begin
              phase_d = (match_q == MW'(NibbleExt)) ? PH_MATCHEXT : PH_OFFSET;
            end
          end
          PH_MATCHEXT: begin
            match_d = mext_ovf ? MW'(LenMax) : MW'(mext_sum[LEN_WIDTH-1:0]);
            if (in_byte_i != ExtByte) begin
              phase_d = PH_OFFSET;
            end
          end
          PH_OFFSET: begin
            if (in_byte_i == EndMarker) begin
              phase_d = PH_DONE;
            end else begin
              match_d = match_q + MW'(MatchMin);
              cpos_d  = wpos_q - AW'(in_byte_i) - AW'(1);
              phase_d = PH_COPY;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // per-beat outputs
  always_comb begin
    step_o           = '0;
    step_o.status    = ST_OK;
    unique case (op)
      OP_DRAIN: begin
        if (phase_q == PH_COPY) begin
          step_o.emit      = 1'b1;
          step_o.hist_we   = 1'b1;
          step_o.from_hist = 1'b1;
        end else begin
          step_o.status = ST_NO_DRAIN;
        end
      end
      OP_DATA: begin
        unique case (phase_q) inside
          PH_FIRST, PH_LITERAL: begin
            step_o.emit    = 1'b1;
            step_o.hist_we = 1'b1;
          end
          PH_LITEXT:   if (lit_ovf)  step_o.status = ST_OVERFLOW;
          PH_MATCHEXT: if (mext_ovf) step_o.status = ST_OVERFLOW;
          PH_COPY:     step_o.status = ST_COPY_BUSY;
          PH_DONE:     step_o.status = ST_AFTER_END;
          default: ;
        endcase
      end
      default: ;
    endcase
    step_o.copy_pending = (phase_d == PH_COPY);
    step_o.done         = (phase_d == PH_DONE);
  end

  assign waddr_o = wpos_q;
  assign raddr_o = cpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      lit_q   <= '0;
      match_q <= '0;
      wpos_q  <= '0;
      cpos_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      match_q <= match_d;
      wpos_q  <= wpos_d;
      cpos_q  <= cpos_d;
    end
  end

endmodule
`default_nettype wire
